FILE: rtl/ftks_pkg.sv
// ----------------------------------------------------------------------------
// ftks_pkg: shared types and constants for the top-k survivor selector
// Holds the entry type that travels along the cell chain and the fixed
// field widths of the stream ports.
// ----------------------------------------------------------------------------
package ftks_pkg;

	localparam int ID_W        = 16;
	localparam int FIT_W       = 32;
	localparam int RANK_W      = 5;
	localparam int POP_W       = 6;
	localparam int S_DATA_W    = 48;
	localparam int M_DATA_W    = 56;
	localparam int MAX_KEEP_DEF = 32;
	localparam int OUT_CAP     = 32;
	localparam int POP_SIZE_RST = 32;

	// 100.0 in signed Q16.16.
	localparam logic signed [FIT_W-1:0] CLAMP_LIMIT = 32'sd6553600;

	typedef struct packed {
		logic             valid;
		logic [FIT_W-1:0] fitness;
		logic [ID_W-1:0]  id;
	} entry_t;

endpackage

FILE: rtl/fitness_top_k_selector_unit.sv
// ----------------------------------------------------------------------------
// fitness_top_k_selector_unit: ranked survivor selection over a cell chain
// Keeps the best candidates in descending fitness order, stable on ties,
// and drains them in rank order on the last candidate.
// ----------------------------------------------------------------------------
// Each candidate item that is taken is compared by every cell of the chain
// with its own entry at once, and each cell either keeps its entry, takes the
// candidate or takes its upper neighbor's entry. After the item marked last,
// the chain drains toward cell 0 at one survivor per cycle while the output
// side takes them; no input item is taken meanwhile. The number of cells is
// the smaller of MAX_KEEP and 32, and pop_size selects how many of them are
// used.
module fitness_top_k_selector_unit #(
	parameter int MAX_KEEP = ftks_pkg::MAX_KEEP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ftks_pkg::POP_W-1:0]     cfg_wdata,   // pop_size
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ftks_pkg::S_DATA_W-1:0]  s_tdata,     // cand_id, cand_fitness
	input  logic                           s_tuser,     // is_incumbent
	input  logic                           s_tlast,     // last_cand
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ftks_pkg::M_DATA_W-1:0]  m_tdata,     // rank, surv_id, surv_fitness, zero pad
	output logic                           m_tlast      // last_out
);
	import ftks_pkg::*;

	localparam int NCELL = (MAX_KEEP < OUT_CAP) ? MAX_KEEP : OUT_CAP;
	localparam int LIM_W = POP_W + 1;
	localparam logic [LIM_W-1:0] NCELL_L = LIM_W'(NCELL);
	localparam logic [LIM_W-1:0] LIM_RST =
		(POP_SIZE_RST < NCELL) ? LIM_W'(POP_SIZE_RST) : LIM_W'(NCELL);

	logic [LIM_W-1:0]  lim_q;
	logic [LIM_W-1:0]  lim_new;
	logic              emit_q;
	logic [RANK_W-1:0] rank_q;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic              out_last_q;

	logic              ins;
	logic              shift;
	logic              last_next;
	logic signed [FIT_W-1:0] raw_fit;
	entry_t            cand;
	entry_t            ent   [NCELL];
	logic              ge    [NCELL];
	logic [NCELL-1:0]  cell_valid;

	always_comb begin
		if (cfg_wdata == '0) begin
			lim_new = LIM_W'(1);
		end else if ({1'b0, cfg_wdata} > NCELL_L) begin
			lim_new = NCELL_L;
		end else begin
			lim_new = {1'b0, cfg_wdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_RST;
		end else if (cfg_we) begin
			lim_q <= lim_new;
		end
	end

	assign raw_fit = $signed(s_tdata[ID_W +: FIT_W]);
	always_comb begin
		cand.valid   = 1'b1;
		cand.id      = s_tdata[ID_W-1:0];
		cand.fitness = (s_tuser && raw_fit > CLAMP_LIMIT) ? '0 : raw_fit;
	end

	assign s_tready = !emit_q;
	assign ins      = s_tvalid && s_tready;
	assign shift    = emit_q && ent[0].valid && (!out_valid_q || m_tready);

	genvar i;
	generate
		for (i = 0; i < NCELL; i++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_ge_i;
			logic   in_lim_i;

			assign in_lim_i = LIM_W'(i) < lim_q;
			if (i == 0) begin : g_head
				assign prev_e    = '0;
				assign prev_ge_i = 1'b1;
			end else begin : g_body
				assign prev_e    = ent[i-1];
				assign prev_ge_i = ge[i-1];
			end
			if (i == NCELL - 1) begin : g_tail
				assign next_e = '0;
			end else begin : g_inner
				assign next_e = ent[i+1];
			end

			ftks_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ins     (ins),
				.shift   (shift),
				.in_lim  (in_lim_i),
				.cand    (cand),
				.prev    (prev_e),
				.prev_ge (prev_ge_i),
				.next    (next_e),
				.ent     (ent[i]),
				.ge      (ge[i])
			);
			assign cell_valid[i] = ent[i].valid;
		end
		if (NCELL > 1) begin : g_last_multi
			assign last_next = !ent[1].valid;
		end else begin : g_last_single
			assign last_next = 1'b1;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q      <= 1'b0;
			rank_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ins && s_tlast) begin
				emit_q <= 1'b1;
				rank_q <= '0;
			end else if (emit_q && !ent[0].valid) begin
				emit_q <= 1'b0;
			end else if (shift) begin
				rank_q <= rank_q + RANK_W'(1);
			end
			if (shift) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			out_data_q <= {{(M_DATA_W - RANK_W - ID_W - FIT_W){1'b0}},
				ent[0].fitness, ent[0].id, rank_q};
			out_last_q <= last_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("last item did not start the drain");

	a_chain_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid >> 1) & ~cell_valid) == '0)
		else $error("cell chain has a hole");

	a_final_empties: assert property (@(posedge clk) disable iff (!arst_n)
		shift && last_next |=> !cell_valid[0])
		else $error("chain not empty after final survivor");
`endif

endmodule

FILE: rtl/ftks_cell.sv
// ----------------------------------------------------------------------------
// ftks_cell: one slot of the sorted insertion chain
// Keeps its entry, takes the candidate or its upper neighbor's entry on an
// insertion, and takes its lower neighbor's entry when the list drains.
// ----------------------------------------------------------------------------
module ftks_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ins,
	input  logic            shift,
	input  logic            in_lim,
	input  ftks_pkg::entry_t cand,
	input  ftks_pkg::entry_t prev,
	input  logic            prev_ge,
	input  ftks_pkg::entry_t next,
	output ftks_pkg::entry_t ent,
	output logic            ge
);
	import ftks_pkg::*;

	logic             valid_q;
	logic [FIT_W-1:0] fitness_q;
	logic [ID_W-1:0]  id_q;
	logic             eff_valid;

	assign eff_valid = valid_q & in_lim;
	assign ge = eff_valid && ($signed(fitness_q) >= $signed(cand.fitness));
	assign ent = '{valid: eff_valid, fitness: fitness_q, id: id_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ins) begin
			valid_q <= in_lim & (ge | prev_ge | prev.valid);
		end else if (shift) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ins) begin
			if (!ge && prev_ge) begin
				fitness_q <= cand.fitness;
				id_q      <= cand.id;
			end else if (!ge) begin
				fitness_q <= prev.fitness;
				id_q      <= prev.id;
			end
		end else if (shift) begin
			fitness_q <= next.fitness;
			id_q      <= next.id;
		end
	end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fitness_top_k_selector_unit
// Streams candidate items through the selector under random sender gaps and
// receiver stalls, predicts the ranked survivor list of each run from its own
// model of the store, and compares every survivor item field by field.
// ----------------------------------------------------------------------------
module testbench;

	import ftks_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 415;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [ID_W-1:0]   id;
		logic [FIT_W-1:0]  fitness;
		logic              last;
	} survivor_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [POP_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;    // cand_id, cand_fitness
	logic                s_tuser = 1'b0;  // is_incumbent
	logic                s_tlast = 1'b0;  // last_cand
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;         // rank, surv_id, surv_fitness, zero pad
	logic                m_tlast;         // last_out

	// Model of the survivor store.
	logic [POP_W-1:0]        pop_setting = POP_W'(POP_SIZE_RST);
	logic signed [FIT_W-1:0] kept_fit [OUT_CAP];
	logic [ID_W-1:0]         kept_ident [OUT_CAP];
	int                      kept_n = 0;
	survivor_t               survivors_due [$];

	int  error_count = 0;
	int  items_sent = 0;
	int  frames_sent = 0;
	int  results_seen = 0;
	int  config_writes = 0;
	int  cycle_count = 0;
	int  burst_left = 0;
	bit  hold_req = 1'b0;

	fitness_top_k_selector_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("fitness_top_k_selector_unit verification failed");
			$finish;
		end
	end

	function automatic int survivor_cap();
		int cap;
		cap = pop_setting;
		if (cap == 0) cap = 1;
		if (cap > MAX_KEEP_DEF) cap = MAX_KEEP_DEF;
		if (cap > OUT_CAP) cap = OUT_CAP;
		return cap;
	endfunction

	task automatic insert_candidate(input logic [ID_W-1:0] id, input logic [FIT_W-1:0] fit,
			input bit incumbent, input bit last);
		int cap;
		int pos;
		int top;
		logic signed [FIT_W-1:0] f;
		survivor_t s;
		cap = survivor_cap();
		if (kept_n > cap) kept_n = cap;
		f = fit;
		if (incumbent && f > CLAMP_LIMIT) f = '0;
		pos = 0;
		for (int i = 0; i < kept_n; i++) begin
			if (kept_fit[i] >= f) pos = i + 1;
		end
		if (pos < cap) begin
			top = (kept_n < cap) ? kept_n : cap - 1;
			for (int i = top; i > pos; i--) begin
				kept_fit[i] = kept_fit[i-1];
				kept_ident[i] = kept_ident[i-1];
			end
			kept_fit[pos] = f;
			kept_ident[pos] = id;
			if (kept_n < cap) kept_n++;
		end
		if (last) begin
			for (int i = 0; i < kept_n; i++) begin
				s.rank = i[RANK_W-1:0];
				s.id = kept_ident[i];
				s.fitness = kept_fit[i];
				s.last = (i == kept_n - 1);
				survivors_due = {survivors_due, s};
			end
			kept_n = 0;
			frames_sent++;
		end
	endtask

	task automatic send_item(input logic [ID_W-1:0] id, input logic [FIT_W-1:0] fit,
			input bit incumbent, input bit last);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 9) >= 6) gap = $urandom_range(1, 6);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= S_DATA_W'({$urandom, $urandom});
			s_tuser <= 1'($urandom_range(0, 1));
			s_tlast <= 1'($urandom_range(0, 1));
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {fit, id};
		s_tuser <= incumbent;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		insert_candidate(id, fit, incumbent, last);
		items_sent++;
		burst_left--;
	endtask

	// Leaves the block idle: stops offering, waits for every survivor, then
	// lets the drain finish.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (survivors_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pop_size(input logic [POP_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		pop_setting = value;
		config_writes++;
	endtask

	function automatic logic [FIT_W-1:0] pick_fitness();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: return ($urandom_range(0, 8) - 4) <<< 16;
			3: return CLAMP_LIMIT + $urandom_range(0, 4) - 2;
			4: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom_range(0, 32'h00C8_0000);
		endcase
	endfunction

	// Incumbents first, then offspring; a few items break that order.
	task automatic send_frame(input int len, input bit with_last);
		int incumbents;
		bit inc;
		incumbents = $urandom_range(0, len);
		for (int j = 0; j < len; j++) begin
			inc = (j < incumbents);
			if ($urandom_range(0, 9) == 0) inc = ~inc;
			send_item(ID_W'($urandom), pick_fitness(), inc, with_last && (j == len - 1));
		end
	endtask

	task automatic test_clamp_and_extremes();
		send_item(16'h0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
		send_item(16'hFFFF, 32'h8000_0000, 1'b0, 1'b0);
		send_item(16'h0101, CLAMP_LIMIT, 1'b1, 1'b0);
		send_item(16'h0102, CLAMP_LIMIT + 1, 1'b1, 1'b0);
		send_item(16'h0103, 32'h7FFF_FFFF, 1'b1, 1'b0);
		send_item(16'h0104, 32'hFFFF_0000, 1'b1, 1'b0);
		send_item(16'h0105, 32'h0000_0000, 1'b0, 1'b0);
		send_item(16'h0106, CLAMP_LIMIT + 1, 1'b0, 1'b1);
		settle();
	endtask

	// A pop_size of zero keeps a single survivor; equal fitness never displaces it.
	task automatic test_single_survivor();
		write_pop_size('0);
		send_item(16'h0201, 32'h0005_0000, 1'b1, 1'b0);
		send_item(16'h0202, 32'h000A_0000, 1'b0, 1'b0);
		send_item(16'h0203, 32'h000A_0000, 1'b0, 1'b0);
		send_item(16'h0204, 32'h0003_0000, 1'b0, 1'b1);
		send_item(16'h0205, 32'hFFF9_0000, 1'b0, 1'b1);
		settle();
	endtask

	// Entries beyond a lowered limit are dropped before the next insertion.
	task automatic test_limit_lowered();
		write_pop_size('1);
		for (int j = 0; j < 6; j++) begin
			send_item(16'h0300 + ID_W'(j), (j * 3 - 7) <<< 16, j[0], 1'b0);
		end
		settle();
		write_pop_size(6'd3);
		send_item(16'h0310, 32'h0000_8000, 1'b0, 1'b1);
		settle();
	endtask

	// The receiver holds off while two runs are offered, so the drain stalls
	// and the input side backs up behind it.
	task automatic test_receiver_hold();
		write_pop_size(6'd32);
		hold_req = 1'b1;
		send_frame(12, 1'b1);
		send_frame(10, 1'b1);
		settle();
	endtask

	task automatic test_random_runs();
		int pop_plan [$] = '{32, 1, 2, 5, 17, 0, 63, 33, 31, 16};
		int plan_idx;
		int len;
		plan_idx = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (plan_idx < pop_plan.size()) write_pop_size(POP_W'(pop_plan[plan_idx]));
			else write_pop_size(POP_W'($urandom_range(0, 63)));
			plan_idx++;
			for (int f = 0; f < 3; f++) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 45)
						: $urandom_range(1, 12);
				send_frame(len, $urandom_range(0, 7) != 0);
			end
			settle();
		end
	endtask

	// Receiver: ready patterns that each hold for a random span, plus one
	// long hold-off on request.
	initial begin
		int rx_mode;
		int rx_span;
		int hold_left;
		rx_mode = 0;
		rx_span = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				if (rx_span == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_span = $urandom_range(8, 64);
				end
				rx_span--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("[%0d] %s mismatch: got %0h, expected %0h", cycle_count, what, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin : check_survivor
		survivor_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (survivors_due.size() == 0) begin
				report_mismatch("unexpected survivor", m_tdata, 0);
			end else begin
				want = survivors_due.pop_front();
				if (m_tdata[4:0] !== want.rank) report_mismatch("rank", m_tdata[4:0], want.rank);
				if (m_tdata[20:5] !== want.id) report_mismatch("surv_id", m_tdata[20:5], want.id);
				if (m_tdata[52:21] !== want.fitness)
					report_mismatch("surv_fitness", m_tdata[52:21], want.fitness);
				if (m_tlast !== want.last) report_mismatch("last_out", m_tlast, want.last);
			end
		end
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		test_clamp_and_extremes();
		test_single_survivor();
		test_limit_lowered();
		test_receiver_hold();
		test_random_runs();
		settle();
		$display("Run covered %0d candidate items in %0d ranked runs, %0d survivors checked,",
				items_sent, frames_sent, results_seen);
		$display("with %0d pop_size writes from 0 to 63 and one long output hold-off.",
				config_writes);
		if (error_count == 0 && survivors_due.size() == 0) begin
			$display("fitness_top_k_selector_unit verification clean");
		end else begin
			$display("%0d mismatches, %0d survivors still due", error_count,
					survivors_due.size());
			$display("fitness_top_k_selector_unit verification failed");
		end
		$finish;
	end

endmodule
